@@ rtl/fpfa_pkg.sv @@
// Shared constants for the fixed-partition fit allocator.
// No dependencies; used by fpfa_table and fixed_partition_fit_allocator_unit.
package fpfa_pkg;

	localparam int NUM_PARTITIONS_DEF = 16;
	localparam int SIZE_BITS_DEF      = 32;

	localparam int OP_W     = 2;
	localparam int PART_W   = 4;
	localparam int AMOUNT_W = 32;
	localparam int POLICY_W = 2;

	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_ROUND = 2'd2;

	localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;
	localparam logic [POLICY_W-1:0] POL_NEXT  = 2'd3;

endpackage

@@ rtl/fpfa_table.sv @@
// Partition table: size and used memories, one write and one read port,
// registered read. Per-entry valid bits give zero reads after reset and zero used reads after round start.
// Depends on fpfa_pkg.
module fpfa_table import fpfa_pkg::*; #(
	parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
	parameter int SIZE_BITS      = SIZE_BITS_DEF,
	localparam int IDX_W         = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr_used,
	input  logic                 wr_en,
	input  logic [IDX_W-1:0]     wr_addr,
	input  logic [SIZE_BITS-1:0] wr_size,
	input  logic [SIZE_BITS-1:0] wr_used,
	input  logic                 rd_en,
	input  logic [IDX_W-1:0]     rd_addr,
	output logic [SIZE_BITS-1:0] rd_size,
	output logic [SIZE_BITS-1:0] rd_used
);

	logic [SIZE_BITS-1:0] size_mem [NUM_PARTITIONS];
	logic [SIZE_BITS-1:0] used_mem [NUM_PARTITIONS];
	logic [SIZE_BITS-1:0] size_rd_q;
	logic [SIZE_BITS-1:0] used_rd_q;

	logic [NUM_PARTITIONS-1:0] ent_vld_q;
	logic [NUM_PARTITIONS-1:0] used_vld_q;
	logic                      ent_rd_vld_q;
	logic                      used_rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			size_mem[wr_addr] <= wr_size;
			used_mem[wr_addr] <= wr_used;
		end
		if (rd_en) begin
			size_rd_q <= size_mem[rd_addr];
			used_rd_q <= used_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q     <= '0;
			used_vld_q    <= '0;
			ent_rd_vld_q  <= 1'b0;
			used_rd_vld_q <= 1'b0;
		end else begin
			if (clr_used) begin
				used_vld_q <= '0;
			end
			if (wr_en) begin
				ent_vld_q[wr_addr]  <= 1'b1;
				used_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				ent_rd_vld_q  <= ent_vld_q[rd_addr];
				used_rd_vld_q <= used_vld_q[rd_addr];
			end
		end
	end

	assign rd_size = ent_rd_vld_q ? size_rd_q : '0;
	assign rd_used = (ent_rd_vld_q && used_rd_vld_q) ? used_rd_q : '0;

endmodule

@@ rtl/fixed_partition_fit_allocator_unit.sv @@
// Fixed-partition fit allocator, top level.
// Depends on fpfa_pkg and fpfa_table.
//
// Usage:
//   Requests enter on start/op/part_index/amount and are taken when start is
//   high and busy is low. Every request gives exactly one result, shown for
//   one cycle with done high; the receiver cannot stall it.
//   Load (op 0) writes a partition size and clears its used amount; round
//   start (op 2) clears all used amounts and the next-fit pointer; op 3 does
//   nothing. These give an all-zero result the cycle after acceptance and
//   never raise busy.
//   Allocate (op 1) scans the table one entry per cycle through the single
//   memory read port, then writes the chosen entry back. The result comes
//   once the scan pipeline has drained, and busy stays high until then, so
//   no new request is taken before the allocate gives its result. A failed
//   allocate returns all zeros and changes nothing.
//   The fit policy register is written on cfg_valid/cfg_ready; cfg_ready is
//   high only while idle with no request offered.
//   Reset clears the whole table (valid bits), the policy and the pointer.
module fixed_partition_fit_allocator_unit import fpfa_pkg::*; #(
	parameter int NUM_PARTITIONS = NUM_PARTITIONS_DEF,
	parameter int SIZE_BITS      = SIZE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [POLICY_W-1:0] cfg_data,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     op,
	input  logic [PART_W-1:0]   part_index,
	input  logic [AMOUNT_W-1:0] amount,
	output logic                done,
	output logic                granted,
	output logic [PART_W-1:0]   chosen_index,
	output logic [AMOUNT_W-1:0] start_offset,
	output logic [AMOUNT_W-1:0] room_left
);

	localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PARTITIONS - 1);
	localparam logic [IDX_W:0]   NUM_P    = (IDX_W + 1)'(NUM_PARTITIONS);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]          state_q;
	logic [IDX_W-1:0]    cnt_q;
	logic [IDX_W-1:0]    base_q;
	logic [IDX_W-1:0]    next_start_q;
	logic [POLICY_W-1:0] policy_q;
	logic [SIZE_BITS-1:0] req_q;

	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 v_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic [SIZE_BITS-1:0] size_s2;
	logic [SIZE_BITS-1:0] used_s2;
	logic [SIZE_BITS-1:0] room_s2;

	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_size_q;
	logic [SIZE_BITS-1:0] best_used_q;
	logic [SIZE_BITS-1:0] best_room_q;

	logic                done_q;
	logic                granted_q;
	logic [PART_W-1:0]   chosen_q;
	logic [AMOUNT_W-1:0] offset_q;
	logic [AMOUNT_W-1:0] room_q;

	logic                 accept;
	logic                 in_range;
	logic                 fin;
	logic                 take;
	logic [SIZE_BITS-1:0] req_in;
	logic [IDX_W:0]       addr_sum;
	logic [IDX_W-1:0]     scan_addr;
	logic                 tbl_clr;
	logic                 tbl_wr_en;
	logic [IDX_W-1:0]     tbl_wr_addr;
	logic [SIZE_BITS-1:0] tbl_wr_size;
	logic [SIZE_BITS-1:0] tbl_wr_used;
	logic                 tbl_rd_en;
	logic [SIZE_BITS-1:0] tbl_rd_size;
	logic [SIZE_BITS-1:0] tbl_rd_used;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy && !start;
	assign accept    = start && !busy;
	assign in_range  = (32'(part_index) < 32'(NUM_PARTITIONS));
	assign req_in    = SIZE_BITS'(amount);

	// next-fit wrap
	assign addr_sum  = {1'b0, base_q} + {1'b0, cnt_q};
	assign scan_addr = (addr_sum >= NUM_P) ? IDX_W'(addr_sum - NUM_P) : IDX_W'(addr_sum);

	assign fin  = (state_q == ST_DRAIN) && !v_s1 && !v_s2;
	assign take = v_s2 && (room_s2 >= req_q) &&
		(!found_q ||
		 ((policy_q == POL_BEST) && (room_s2 < best_room_q)) ||
		 ((policy_q == POL_WORST) && (room_s2 > best_room_q)));

	assign tbl_clr     = accept && (op == OP_ROUND);
	assign tbl_wr_en   = (accept && (op == OP_LOAD) && in_range) || (fin && found_q);
	assign tbl_wr_addr = fin ? best_idx_q : IDX_W'(part_index);
	assign tbl_wr_size = fin ? best_size_q : req_in;
	assign tbl_wr_used = fin ? best_used_q + req_q : '0;
	assign tbl_rd_en   = (state_q == ST_SCAN);

	fpfa_table #(
		.NUM_PARTITIONS(NUM_PARTITIONS),
		.SIZE_BITS     (SIZE_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr_used(tbl_clr),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_size (tbl_wr_size),
		.wr_used (tbl_wr_used),
		.rd_en   (tbl_rd_en),
		.rd_addr (scan_addr),
		.rd_size (tbl_rd_size),
		.rd_used (tbl_rd_used)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			base_q       <= '0;
			next_start_q <= '0;
			policy_q     <= POL_FIRST;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			found_q      <= 1'b0;
			done_q       <= 1'b0;
			granted_q    <= 1'b0;
			chosen_q     <= '0;
			offset_q     <= '0;
			room_q       <= '0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= tbl_rd_en;
			v_s2   <= v_s1;
			if (cfg_valid && cfg_ready) begin
				policy_q <= cfg_data;
			end
			if (take) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (op == OP_ALLOC) begin
							state_q <= ST_SCAN;
							cnt_q   <= '0;
							base_q  <= (policy_q == POL_NEXT) ? next_start_q : '0;
							found_q <= 1'b0;
						end else begin
							done_q    <= 1'b1;
							granted_q <= 1'b0;
							chosen_q  <= '0;
							offset_q  <= '0;
							room_q    <= '0;
							if (op == OP_ROUND) begin
								next_start_q <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_IDX) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (fin) begin
						state_q   <= ST_IDLE;
						done_q    <= 1'b1;
						granted_q <= found_q;
						chosen_q  <= found_q ? PART_W'(best_idx_q) : '0;
						offset_q  <= found_q ? AMOUNT_W'(best_used_q) : '0;
						room_q    <= found_q ? AMOUNT_W'(best_room_q - req_q) : '0;
						if (found_q && (policy_q == POL_NEXT)) begin
							next_start_q <= best_idx_q;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (op == OP_ALLOC)) begin
			req_q <= req_in;
		end
		idx_s1  <= scan_addr;
		idx_s2  <= idx_s1;
		size_s2 <= tbl_rd_size;
		used_s2 <= tbl_rd_used;
		room_s2 <= tbl_rd_size - tbl_rd_used;
		if (take) begin
			best_idx_q  <= idx_s2;
			best_size_q <= size_s2;
			best_used_q <= used_s2;
			best_room_q <= room_s2;
		end
	end

	assign done         = done_q;
	assign granted      = granted_q;
	assign chosen_index = chosen_q;
	assign start_offset = offset_q;
	assign room_left    = room_q;

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (!v_s1 && !v_s2))
		else $error("scan pipeline not empty while idle");

	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op == OP_ALLOC)) |=> (busy && !done))
		else $error("allocate did not start a scan");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !granted) |-> (chosen_index == '0 && start_offset == '0 && room_left == '0))
		else $error("non-granted result carries data");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !tbl_wr_en)
		else $error("table written during scan");

endmodule
